// ===== hdl/depth_tested_framebuffer_top_defines.svh =====
// Assertion macros used by the framebuffer controller RTL.
`ifndef DEPTH_TESTED_FRAMEBUFFER_TOP_DEFINES_SVH
`define DEPTH_TESTED_FRAMEBUFFER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked every clock edge, ignored while reset is asserted.
`define DTFB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked every clock edge, reset included.
`define DTFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define DTFB_ASSERT(lbl, prop, msg)
`define DTFB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/dtfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dtfb_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int DIM_RESET      = 256;

    localparam logic [31:0] DEPTH_INF = 32'h7F80_0000;

    localparam logic [2:0] K_CLEAR_ALL   = 3'd0;
    localparam logic [2:0] K_CLEAR_DEPTH = 3'd1;
    localparam logic [2:0] K_PLAIN_WR    = 3'd2;
    localparam logic [2:0] K_TESTED_WR   = 3'd3;
    localparam logic [2:0] K_READ        = 3'd4;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic latch;
        logic calc;
        logic acc;
        logic cmp;
        logic sweep_init;
        logic sweep_item;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic sweep_last;
        logic out_free;
    } t_status;

    function automatic logic f_is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    function automatic logic f_is_finite(input logic [31:0] b);
        return b[30:23] != 8'hFF;
    endfunction

    // Monotone key for non-NaN singles, -0 folded onto +0.
    function automatic logic [31:0] f_key(input logic [31:0] b);
        logic [31:0] v;
        v = (b[30:0] == 31'd0) ? 32'd0 : b;
        return v[31] ? ~v : (v | 32'h8000_0000);
    endfunction

endpackage
`default_nettype wire

// ===== hdl/dtfb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== hdl/dtfb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "depth_tested_framebuffer_top_defines.svh"
module dtfb_ctrl
    import dtfb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);
    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_ADDR = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_RES  = 3'd6;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.sweep_init = 1'b1;
                if (i_st.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc = 1'b1;
                n_state    = i_st.is_clear ? S_CLR : S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = S_RES;
            end
            S_CLR: begin
                o_cmd.sweep_item = 1'b1;
                if (i_st.sweep_last) n_state = S_RES;
            end
            S_RES: begin
                if (i_st.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    `DTFB_ASSERT(a_cmd_excl, $onehot0(o_cmd), "more than one datapath command")
    `DTFB_ASSERT(a_load_free, o_cmd.load_out |-> i_st.out_free, "result loaded over a pending one")
    `DTFB_ASSERT(a_sweep_end, (o_cmd.sweep_item && i_st.sweep_last) |=> (r_state == S_RES), "clear did not end in result")
    `DTFB_ASSERT(a_accept_addr, o_cmd.latch |=> (r_state == S_ADDR), "accepted word not decoded")
endmodule
`default_nettype wire

// ===== hdl/dtfb_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dtfb_dp
    import dtfb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    localparam int WB    = $clog2(MAX_WIDTH + 1),
    localparam int HB    = $clog2(MAX_HEIGHT + 1),
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd          i_cmd,
    output t_status            o_st,
    input  wire logic [WB-1:0] i_width,
    input  wire logic [HB-1:0] i_height,
    input  wire logic [2:0]    i_kind,
    input  wire logic [15:0]   i_pos_x,
    input  wire logic [15:0]   i_pos_y,
    input  wire logic [31:0]   i_depth_bits,
    input  wire logic [31:0]   i_pixel_color,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic               o_written,
    output logic      [31:0]   o_read_color,
    output logic      [31:0]   o_read_depth
);
    logic [2:0]    r_kind;
    logic [15:0]   r_px, r_py;
    logic [31:0]   r_depth, r_color;
    logic [AW-1:0] r_addr;
    logic          r_inside;
    logic [AW-1:0] r_sweep;
    logic          r_res_w;
    logic [31:0]   r_res_c, r_res_d;
    logic          r_ovalid;

    logic          w_inside;
    logic [31:0]   w_prod;
    logic [31:0]   w_old_c, w_old_d;
    logic          w_pass;
    logic          w_last;

    // Position check and linear address, registered before the store access.
    assign w_inside = !r_px[15] && !r_py[15]
                   && (32'(r_px[14:0]) < 32'(i_width))
                   && (32'(r_py[14:0]) < 32'(i_height));
    assign w_prod = 32'(r_py[14:0]) * 32'(i_width) + 32'(r_px[14:0]);

    assign w_last = (r_sweep == AW'(DEPTH - 1));
    assign w_pass = f_is_finite(r_depth)
                 && (f_is_nan(w_old_d) || (f_key(r_depth) < f_key(w_old_d)));

    assign o_st.is_clear   = (r_kind == K_CLEAR_ALL) || (r_kind == K_CLEAR_DEPTH);
    assign o_st.sweep_last = w_last;
    assign o_st.out_free   = !r_ovalid || !i_stall;

    logic          w_c_we, w_d_we;
    logic [AW-1:0] w_c_wa, w_d_wa;
    logic [31:0]   w_c_wd, w_d_wd;
    logic          w_sweep;
    logic          w_test_wr;

    assign w_sweep   = i_cmd.sweep_init || i_cmd.sweep_item;
    assign w_test_wr = i_cmd.cmp && r_inside && (r_kind == K_TESTED_WR) && w_pass;

    always_comb begin
        if (w_sweep) begin
            w_c_we = i_cmd.sweep_init || (r_kind == K_CLEAR_ALL);
            w_c_wa = r_sweep;
            w_c_wd = i_cmd.sweep_init ? 32'd0 : r_color;
            w_d_we = 1'b1;
            w_d_wa = r_sweep;
            w_d_wd = (i_cmd.sweep_item && r_kind == K_CLEAR_DEPTH) ? r_depth : DEPTH_INF;
        end else begin
            w_c_we = (i_cmd.acc && r_inside && r_kind == K_PLAIN_WR) || w_test_wr;
            w_c_wa = r_addr;
            w_c_wd = r_color;
            w_d_we = w_test_wr;
            w_d_wa = r_addr;
            w_d_wd = r_depth;
        end
    end

    dtfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_color (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_wa),
        .i_wdata (w_c_wd),
        .i_re    (i_cmd.acc),
        .i_raddr (r_addr),
        .o_rdata (w_old_c)
    );

    dtfb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_depth (
        .i_clk   (i_clk),
        .i_we    (w_d_we),
        .i_waddr (w_d_wa),
        .i_wdata (w_d_wd),
        .i_re    (i_cmd.acc),
        .i_raddr (r_addr),
        .o_rdata (w_old_d)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind  <= i_kind;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_depth <= i_depth_bits;
            r_color <= i_pixel_color;
        end
        if (i_cmd.calc) begin
            r_inside <= w_inside;
            r_addr   <= w_prod[AW-1:0];
        end
        if (i_cmd.cmp) begin
            r_res_w <= r_inside && ((r_kind == K_PLAIN_WR) || (r_kind == K_TESTED_WR && w_pass));
            r_res_c <= (r_inside && r_kind == K_READ) ? w_old_c : 32'd0;
            r_res_d <= (r_inside && r_kind == K_READ) ? w_old_d : 32'd0;
        end else if (i_cmd.sweep_item && w_last) begin
            r_res_w <= 1'b1;
            r_res_c <= 32'd0;
            r_res_d <= 32'd0;
        end
        if (i_cmd.load_out) begin
            o_written    <= r_res_w;
            o_read_color <= r_res_c;
            o_read_depth <= r_res_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_sweep) begin
                r_sweep <= w_last ? '0 : r_sweep + AW'(1);
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
endmodule
`default_nettype wire

// ===== hdl/depth_tested_framebuffer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Depth-tested framebuffer: colour and depth stores of MAX_WIDTH*MAX_HEIGHT words each,
// addressed y*active_width+x, one word in, one result word out per item, one item at a time.
// A plain write, tested write, read or unused kind goes through decode/address multiply,
// store read, compare/write and result load, and the next word is taken once the result
// is loaded; a clear walks the stores one address a cycle (the colour store is written only
// by a clear-all), then loads its result. While the previous result is stalled on the
// output the input stays stalled. After reset the stores are initialized by a pass over
// every address during which o_stall stays high; register writes over APB are taken at any
// time but are meant for when the block is idle.
module depth_tested_framebuffer_top
    import dtfb_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [15:0] i_pos_x,
    input  wire logic [15:0] i_pos_y,
    input  wire logic [31:0] i_depth_bits,
    input  wire logic [31:0] i_pixel_color,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_written,
    output logic      [31:0] o_read_color,
    output logic      [31:0] o_read_depth
);
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
    localparam int H_RST = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

    logic [WB-1:0] r_width;
    logic [HB-1:0] r_height;
    logic          w_wr;
    logic [8:0]    w_val;
    logic [WB-1:0] w_width_sat;
    logic [HB-1:0] w_height_sat;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_val  = pwdata[8:0];

    // Saturate to 1..MAX.
    assign w_width_sat  = (w_val == 9'd0) ? WB'(1) :
                          (32'(w_val) > 32'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(w_val);
    assign w_height_sat = (w_val == 9'd0) ? HB'(1) :
                          (32'(w_val) > 32'(MAX_HEIGHT)) ? HB'(MAX_HEIGHT) : HB'(w_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WB'(W_RST);
            r_height <= HB'(H_RST);
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_WIDTH:  r_width  <= w_width_sat;
                REG_HEIGHT: r_height <= w_height_sat;
                default:    r_width  <= r_width;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(r_height) : 32'(r_width);

    t_cmd    w_cmd;
    t_status w_st;

    dtfb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_st    (w_st),
        .o_cmd   (w_cmd)
    );

    dtfb_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_st          (w_st),
        .i_width       (r_width),
        .i_height      (r_height),
        .i_kind        (i_kind),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_depth_bits  (i_depth_bits),
        .i_pixel_color (i_pixel_color),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_written     (o_written),
        .o_read_color  (o_read_color),
        .o_read_depth  (o_read_depth)
    );
endmodule
`default_nettype wire

// ===== tb/sv/depth_tested_framebuffer_top_tb.sv =====
`timescale 1ns / 1ps
module depth_tested_framebuffer_top_tb;
    import dtfb_pkg::*;

    localparam int STORE_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_CLEARS  = 7;
    localparam logic [2:0] ADDR_WIDTH  = {REG_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_HEIGHT, 2'b00};
    localparam logic [31:0] NEG_INF  = 32'hFF80_0000;
    localparam logic [31:0] NEG_ZERO = 32'h8000_0000;
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;

    typedef struct {
        logic        written;
        logic [31:0] color;
        logic [31:0] depth;
    } fb_result_t;

    class fb_scoreboard;
        logic [31:0] color_mem[STORE_WORDS];
        logic [31:0] depth_mem[STORE_WORDS];
        int unsigned width_cfg, height_cfg;
        fb_result_t  expected_q[$];
        int          errors, checked;

        function void clear_state();
            for (int i = 0; i < STORE_WORDS; i++) begin
                color_mem[i] = 32'd0;
                depth_mem[i] = DEPTH_INF;
            end
            width_cfg  = MAX_WIDTH_DEF;
            height_cfg = MAX_HEIGHT_DEF;
        endfunction

        function int unsigned clamp_dim(logic [31:0] v, int unsigned maxv);
            logic [8:0] m;
            m = v[8:0];
            if (m == 0) return 1;
            if (m > maxv) return maxv;
            return m;
        endfunction

        function void set_reg(logic [2:0] addr, logic [31:0] v);
            if (addr == ADDR_WIDTH) width_cfg = clamp_dim(v, MAX_WIDTH_DEF);
            else if (addr == ADDR_HEIGHT) height_cfg = clamp_dim(v, MAX_HEIGHT_DEF);
        endfunction

        // monotone compare key, -0 folded onto +0
        function logic [31:0] depth_key(logic [31:0] b);
            if (b[30:0] == 31'd0) b = 32'd0;
            return b[31] ? ~b : (b | 32'h8000_0000);
        endfunction

        function void note_item(logic [2:0] kind, logic [15:0] px, logic [15:0] py,
                                logic [31:0] dep, logic [31:0] col);
            fb_result_t r;
            bit in_area;
            int unsigned a;
            r = '{1'b0, 32'd0, 32'd0};
            in_area = !px[15] && !py[15] && px < width_cfg && py < height_cfg;
            a = in_area ? py * width_cfg + px : 0;
            case (kind)
                K_CLEAR_ALL: begin
                    for (int i = 0; i < STORE_WORDS; i++) begin
                        color_mem[i] = col;
                        depth_mem[i] = DEPTH_INF;
                    end
                    r.written = 1'b1;
                end
                K_CLEAR_DEPTH: begin
                    for (int i = 0; i < STORE_WORDS; i++) depth_mem[i] = dep;
                    r.written = 1'b1;
                end
                K_PLAIN_WR: begin
                    if (in_area) begin
                        color_mem[a] = col;
                        r.written = 1'b1;
                    end
                end
                K_TESTED_WR: begin
                    if (in_area && dep[30:23] != 8'hFF) begin
                        logic [31:0] old;
                        old = depth_mem[a];
                        // stored NaN loses to any finite depth
                        if ((old[30:23] == 8'hFF && old[22:0] != 0) ||
                            depth_key(dep) < depth_key(old)) begin
                            depth_mem[a] = dep;
                            color_mem[a] = col;
                            r.written = 1'b1;
                        end
                    end
                end
                K_READ: begin
                    if (in_area) begin
                        r.color = color_mem[a];
                        r.depth = depth_mem[a];
                    end
                end
                default: ;
            endcase
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(logic w, logic [31:0] c, logic [31:0] d);
            fb_result_t e;
            checked++;
            if (expected_q.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            e = expected_q.pop_front();
            if (w !== e.written) report($sformatf("written %b exp %b", w, e.written));
            if (c !== e.color) report($sformatf("read_color %h exp %h", c, e.color));
            if (d !== e.depth) report($sformatf("read_depth %h exp %h", d, e.depth));
        endtask
    endclass

    logic        i_clk, i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        i_valid, o_stall, o_valid, i_stall, o_written;
    logic [2:0]  i_kind;
    logic [15:0] i_pos_x, i_pos_y;
    logic [31:0] i_depth_bits, i_pixel_color, o_read_color, o_read_depth;

    fb_scoreboard fb_sb;
    bit quiet;
    int cycles, clears_sent, items_sent;

    depth_tested_framebuffer_top dut (.*);

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall) fb_sb.check_result(o_written, o_read_color,
                                                               o_read_depth);

    // result-side stall bursts
    initial begin
        @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task apb_write(logic [2:0] addr, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        fb_sb.set_reg(addr, v);
        @(posedge i_clk);
    endtask

    task wait_drained();
        i_valid <= 1'b0;
        while (fb_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task send_word(logic [2:0] kind, logic [15:0] px, logic [15:0] py,
                   logic [31:0] dep, logic [31:0] col);
        i_valid <= 1'b1; i_kind <= kind; i_pos_x <= px; i_pos_y <= py;
        i_depth_bits <= dep; i_pixel_color <= col;
        do @(posedge i_clk); while (o_stall);
        fb_sb.note_item(kind, px, py, dep, col);
        items_sent++;
        if (kind == K_CLEAR_ALL || kind == K_CLEAR_DEPTH) clears_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    function logic [31:0] pick_depth();
        case ($urandom_range(0, 11))
            0, 1: return $urandom;
            2: return 32'd0;
            3: return NEG_ZERO;
            4: return DEPTH_INF;
            5: return NEG_INF;
            6: return QNAN | $urandom_range(0, 32'h3F_FFFF) | ($urandom_range(0, 1) << 31);
            default: return {1'($urandom_range(0, 1)), 8'(120 + $urandom_range(0, 12)),
                             23'($urandom)};
        endcase
    endfunction

    function logic [15:0] pick_pos(int unsigned lim);
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        return 16'($urandom_range(0, lim));
    endfunction

    task random_items(int n);
        logic [2:0] k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: k = (clears_sent < MAX_CLEARS && $urandom_range(0, 5) == 0)
                       ? (($urandom_range(0, 1) != 0) ? K_CLEAR_ALL : K_CLEAR_DEPTH)
                       : K_READ;
                1: k = 3'($urandom_range(5, 7));
                2, 3, 4: k = K_PLAIN_WR;
                5, 6, 7, 8, 9, 10, 11: k = K_TESTED_WR;
                default: k = K_READ;
            endcase
            send_word(k, pick_pos(fb_sb.width_cfg), pick_pos(fb_sb.height_cfg),
                      pick_depth(), $urandom);
        end
    endtask

    int unsigned cfg_w[6] = '{1, 32'h200, 300, 5, 17, 256};
    int unsigned cfg_h[6] = '{1, 7, 3, 256, 9, 256};

    initial begin
        fb_sb = new();
        fb_sb.clear_state();
        i_rst_n = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0;
        pwdata = '0; i_valid = 1'b0; i_stall = 1'b0; i_kind = K_READ; i_pos_x = '0;
        i_pos_y = '0; i_depth_bits = '0; i_pixel_color = '0;
        quiet = 1'b0; cycles = 0; clears_sent = 0; items_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, full 256x256 area
        apb_write(ADDR_WIDTH, 256);
        apb_write(ADDR_HEIGHT, 256);
        send_word(K_READ, 16'd255, 16'd255, 0, 0);
        send_word(K_CLEAR_ALL, 16'd0, 16'd0, 0, 32'hFFFF_FFFF);
        send_word(K_PLAIN_WR, 16'd255, 16'd255, 0, 32'hA5A5_5A5A);
        send_word(K_READ, 16'd255, 16'd255, 0, 0);
        send_word(K_PLAIN_WR, 16'd256, 16'd0, 0, 32'h1);
        send_word(K_PLAIN_WR, 16'hFFFF, 16'd0, 0, 32'h1);
        send_word(K_TESTED_WR, 16'd0, 16'd0, 32'd0, 32'h1111_1111);
        send_word(K_TESTED_WR, 16'd0, 16'd0, NEG_ZERO, 32'h2222_2222);
        send_word(K_TESTED_WR, 16'd0, 16'd0, 32'hBF80_0000, 32'h3333_3333);
        send_word(K_TESTED_WR, 16'd0, 16'd0, NEG_INF, 32'h4444_4444);
        send_word(K_TESTED_WR, 16'd1, 16'd0, DEPTH_INF, 32'h5555_5555);
        send_word(K_TESTED_WR, 16'd1, 16'd0, QNAN, 32'h6666_6666);
        send_word(K_READ, 16'd0, 16'd0, 0, 0);
        send_word(K_READ, 16'h8000, 16'h7FFF, 0, 0);
        send_word(K_CLEAR_DEPTH, 16'd0, 16'd0, 32'h7F80_0001, 0);
        send_word(K_READ, 16'd10, 16'd20, 0, 0);
        send_word(K_TESTED_WR, 16'd10, 16'd20, 32'h7F7F_FFFF, 32'h7777_7777);
        send_word(K_READ, 16'd10, 16'd20, 0, 0);
        send_word(3'd5, 16'd1, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(3'd6, 16'd0, 16'd0, 0, 0);
        send_word(3'd7, 16'h7FFF, 16'h8000, 0, 0);
        random_items(80);

        // each setting runs with the block drained first
        for (int p = 0; p < 6; p++) begin
            wait_drained();
            apb_write(ADDR_WIDTH, cfg_w[p]);
            apb_write(ADDR_HEIGHT, cfg_h[p]);
            if (p == 5) quiet = 1'b1;
            random_items(85);
        end

        i_valid <= 1'b0;
        while (fb_sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words (%0d clears) over 7 area settings, checked %0d results",
                 items_sent, clears_sent, fb_sb.checked);
        if (fb_sb.errors == 0 && fb_sb.expected_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
